// ===== src/perlin_gradient_noise_3d_unit_defines.svh =====
// Assertion macros for the gradient noise unit.
// Included by the top level; no other dependency.
`ifndef PERLIN_GRADIENT_NOISE_3D_UNIT_DEFINES_SVH
`define PERLIN_GRADIENT_NOISE_3D_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PGN_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PGN_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PGN_ASSERT_IMPL(label, prop, msg)
`define PGN_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== src/pgn_pkg.sv =====
// Shared constants, types and functions of the gradient noise unit.
// No dependencies.
package pgn_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int OUT_W     = 18;
    localparam int FW        = 21;   // signed working width, holds the fade constants up to 15

    typedef logic [7:0] idx_t;

    function automatic logic [7:0] perm(input logic [7:0] i);
        logic [7:0] r;
        case (i)
            8'd0: r=8'd151; 8'd1: r=8'd160; 8'd2: r=8'd137; 8'd3: r=8'd91;
            8'd4: r=8'd90; 8'd5: r=8'd15; 8'd6: r=8'd131; 8'd7: r=8'd13;
            8'd8: r=8'd201; 8'd9: r=8'd95; 8'd10: r=8'd96; 8'd11: r=8'd53;
            8'd12: r=8'd194; 8'd13: r=8'd233; 8'd14: r=8'd7; 8'd15: r=8'd225;
            8'd16: r=8'd140; 8'd17: r=8'd36; 8'd18: r=8'd103; 8'd19: r=8'd30;
            8'd20: r=8'd69; 8'd21: r=8'd142; 8'd22: r=8'd8; 8'd23: r=8'd99;
            8'd24: r=8'd37; 8'd25: r=8'd240; 8'd26: r=8'd21; 8'd27: r=8'd10;
            8'd28: r=8'd23; 8'd29: r=8'd190; 8'd30: r=8'd6; 8'd31: r=8'd148;
            8'd32: r=8'd247; 8'd33: r=8'd120; 8'd34: r=8'd234; 8'd35: r=8'd75;
            8'd36: r=8'd0; 8'd37: r=8'd26; 8'd38: r=8'd197; 8'd39: r=8'd62;
            8'd40: r=8'd94; 8'd41: r=8'd252; 8'd42: r=8'd219; 8'd43: r=8'd203;
            8'd44: r=8'd117; 8'd45: r=8'd35; 8'd46: r=8'd11; 8'd47: r=8'd32;
            8'd48: r=8'd57; 8'd49: r=8'd177; 8'd50: r=8'd33; 8'd51: r=8'd88;
            8'd52: r=8'd237; 8'd53: r=8'd149; 8'd54: r=8'd56; 8'd55: r=8'd87;
            8'd56: r=8'd174; 8'd57: r=8'd20; 8'd58: r=8'd125; 8'd59: r=8'd136;
            8'd60: r=8'd171; 8'd61: r=8'd168; 8'd62: r=8'd68; 8'd63: r=8'd175;
            8'd64: r=8'd74; 8'd65: r=8'd165; 8'd66: r=8'd71; 8'd67: r=8'd134;
            8'd68: r=8'd139; 8'd69: r=8'd48; 8'd70: r=8'd27; 8'd71: r=8'd166;
            8'd72: r=8'd77; 8'd73: r=8'd146; 8'd74: r=8'd158; 8'd75: r=8'd231;
            8'd76: r=8'd83; 8'd77: r=8'd111; 8'd78: r=8'd229; 8'd79: r=8'd122;
            8'd80: r=8'd60; 8'd81: r=8'd211; 8'd82: r=8'd133; 8'd83: r=8'd230;
            8'd84: r=8'd220; 8'd85: r=8'd105; 8'd86: r=8'd92; 8'd87: r=8'd41;
            8'd88: r=8'd55; 8'd89: r=8'd46; 8'd90: r=8'd245; 8'd91: r=8'd40;
            8'd92: r=8'd244; 8'd93: r=8'd102; 8'd94: r=8'd143; 8'd95: r=8'd54;
            8'd96: r=8'd65; 8'd97: r=8'd25; 8'd98: r=8'd63; 8'd99: r=8'd161;
            8'd100: r=8'd1; 8'd101: r=8'd216; 8'd102: r=8'd80; 8'd103: r=8'd73;
            8'd104: r=8'd209; 8'd105: r=8'd76; 8'd106: r=8'd132; 8'd107: r=8'd187;
            8'd108: r=8'd208; 8'd109: r=8'd89; 8'd110: r=8'd18; 8'd111: r=8'd169;
            8'd112: r=8'd200; 8'd113: r=8'd196; 8'd114: r=8'd135; 8'd115: r=8'd130;
            8'd116: r=8'd116; 8'd117: r=8'd188; 8'd118: r=8'd159; 8'd119: r=8'd86;
            8'd120: r=8'd164; 8'd121: r=8'd100; 8'd122: r=8'd109; 8'd123: r=8'd198;
            8'd124: r=8'd173; 8'd125: r=8'd186; 8'd126: r=8'd3; 8'd127: r=8'd64;
            8'd128: r=8'd52; 8'd129: r=8'd217; 8'd130: r=8'd226; 8'd131: r=8'd250;
            8'd132: r=8'd124; 8'd133: r=8'd123; 8'd134: r=8'd5; 8'd135: r=8'd202;
            8'd136: r=8'd38; 8'd137: r=8'd147; 8'd138: r=8'd118; 8'd139: r=8'd126;
            8'd140: r=8'd255; 8'd141: r=8'd82; 8'd142: r=8'd85; 8'd143: r=8'd212;
            8'd144: r=8'd207; 8'd145: r=8'd206; 8'd146: r=8'd59; 8'd147: r=8'd227;
            8'd148: r=8'd47; 8'd149: r=8'd16; 8'd150: r=8'd58; 8'd151: r=8'd17;
            8'd152: r=8'd182; 8'd153: r=8'd189; 8'd154: r=8'd28; 8'd155: r=8'd42;
            8'd156: r=8'd223; 8'd157: r=8'd183; 8'd158: r=8'd170; 8'd159: r=8'd213;
            8'd160: r=8'd119; 8'd161: r=8'd248; 8'd162: r=8'd152; 8'd163: r=8'd2;
            8'd164: r=8'd44; 8'd165: r=8'd154; 8'd166: r=8'd163; 8'd167: r=8'd70;
            8'd168: r=8'd221; 8'd169: r=8'd153; 8'd170: r=8'd101; 8'd171: r=8'd155;
            8'd172: r=8'd167; 8'd173: r=8'd43; 8'd174: r=8'd172; 8'd175: r=8'd9;
            8'd176: r=8'd129; 8'd177: r=8'd22; 8'd178: r=8'd39; 8'd179: r=8'd253;
            8'd180: r=8'd19; 8'd181: r=8'd98; 8'd182: r=8'd108; 8'd183: r=8'd110;
            8'd184: r=8'd79; 8'd185: r=8'd113; 8'd186: r=8'd224; 8'd187: r=8'd232;
            8'd188: r=8'd178; 8'd189: r=8'd185; 8'd190: r=8'd112; 8'd191: r=8'd104;
            8'd192: r=8'd218; 8'd193: r=8'd246; 8'd194: r=8'd97; 8'd195: r=8'd228;
            8'd196: r=8'd251; 8'd197: r=8'd34; 8'd198: r=8'd242; 8'd199: r=8'd193;
            8'd200: r=8'd238; 8'd201: r=8'd210; 8'd202: r=8'd144; 8'd203: r=8'd12;
            8'd204: r=8'd191; 8'd205: r=8'd179; 8'd206: r=8'd162; 8'd207: r=8'd241;
            8'd208: r=8'd81; 8'd209: r=8'd51; 8'd210: r=8'd145; 8'd211: r=8'd235;
            8'd212: r=8'd249; 8'd213: r=8'd14; 8'd214: r=8'd239; 8'd215: r=8'd107;
            8'd216: r=8'd49; 8'd217: r=8'd192; 8'd218: r=8'd214; 8'd219: r=8'd31;
            8'd220: r=8'd181; 8'd221: r=8'd199; 8'd222: r=8'd106; 8'd223: r=8'd157;
            8'd224: r=8'd184; 8'd225: r=8'd84; 8'd226: r=8'd204; 8'd227: r=8'd176;
            8'd228: r=8'd115; 8'd229: r=8'd121; 8'd230: r=8'd50; 8'd231: r=8'd45;
            8'd232: r=8'd127; 8'd233: r=8'd4; 8'd234: r=8'd150; 8'd235: r=8'd254;
            8'd236: r=8'd138; 8'd237: r=8'd236; 8'd238: r=8'd205; 8'd239: r=8'd93;
            8'd240: r=8'd222; 8'd241: r=8'd114; 8'd242: r=8'd67; 8'd243: r=8'd29;
            8'd244: r=8'd24; 8'd245: r=8'd72; 8'd246: r=8'd243; 8'd247: r=8'd141;
            8'd248: r=8'd128; 8'd249: r=8'd195; 8'd250: r=8'd78; 8'd251: r=8'd66;
            8'd252: r=8'd215; 8'd253: r=8'd61; 8'd254: r=8'd156; default: r=8'd180;
        endcase
        return r;
    endfunction

    // Signed product of two working values, floored to FRAC_BITS fraction bits.
    function automatic logic signed [FW-1:0] fx_mul(input logic signed [FW-1:0] a,
                                                    input logic signed [FW-1:0] b);
        logic signed [2*FW-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: FW];
    endfunction

    // Gradient dot product for the low four bits of a hash.
    function automatic logic signed [FW-1:0] edge_dot(input logic [3:0] k,
        input logic signed [FW-1:0] dx, input logic signed [FW-1:0] dy,
        input logic signed [FW-1:0] dz);
        logic signed [FW-1:0] u;
        logic signed [FW-1:0] v;
        u = (k < 4'd8) ? dx : dy;
        v = (k < 4'd4) ? dy : ((k == 4'd12 || k == 4'd14) ? dx : dz);
        return (k[0] ? -u : u) + (k[1] ? -v : v);
    endfunction
endpackage

// ===== src/pgn_fade.sv =====
// Pipelined fade curve 6t^5 - 15t^4 + 10t^3, three register stages.
// Depends on pgn_pkg.
module pgn_fade (
    input  logic                            clk,
    input  logic                            en,
    input  logic [pgn_pkg::FRAC_BITS-1:0]   t,
    output logic signed [pgn_pkg::FW-1:0]   fade
);
    import pgn_pkg::*;

    logic signed [FW-1:0] t1_reg, tt_reg, lin_reg;
    logic signed [FW-1:0] t3_reg, in_reg, fade_reg;
    logic signed [FW-1:0] t_ext;

    assign t_ext = FW'($unsigned(t));

    // Square t and form 6t - 15.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t_ext;
            tt_reg  <= fx_mul(t_ext, t_ext);
            lin_reg <= FW'(6 * t_ext) - FW'(15 << FRAC_BITS);
        end
    end

    // Cube and inner polynomial.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_reg <= fx_mul(tt_reg, t1_reg);
            in_reg <= fx_mul(t1_reg, lin_reg) + FW'(10 << FRAC_BITS);
        end
    end

    // Final product.
    always_ff @(posedge clk)
    begin
        if (en)
            fade_reg <= fx_mul(t3_reg, in_reg);
    end

    assign fade = fade_reg;
endmodule

// ===== src/perlin_gradient_noise_3d_unit.sv =====
// Channel  Handshake         Payload
// in       in_valid/stall    x_coord, y_coord, z_coord (Q16.16)
// out      out_valid/out_stall noise_value (Q2.16)
// Seven register stages, one point per clock unless out_stall holds the pipeline.
// The hash chain (three dependent permutation lookups) and the lerp tree set the depth.
// Reset clears the valid bits only. out_stall freezes the whole pipeline while out_valid is high.
// Depends on pgn_pkg, pgn_fade and the defines header.
`include "perlin_gradient_noise_3d_unit_defines.svh"
module perlin_gradient_noise_3d_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 stall,
    input  logic signed [pgn_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [pgn_pkg::COORD_W-1:0]   y_coord,
    input  logic signed [pgn_pkg::COORD_W-1:0]   z_coord,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pgn_pkg::OUT_W-1:0]     noise_value
);
    import pgn_pkg::*;

    localparam int NS = 7;
    logic [NS-1:0] v_reg;
    logic          en;

    // Advance everything unless a held result blocks the output.
    assign en    = !(v_reg[NS-1] && out_stall);
    assign stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], in_valid};
    end

    // Fraction delay lines: carry f per axis up to the dot product stage.
    logic signed [FW-1:0] fx_reg [3];
    logic signed [FW-1:0] fy_reg [3];
    logic signed [FW-1:0] fz_reg [3];
    logic signed [FW-1:0] ax, ay, az;
    assign ax = FW'($unsigned(x_coord[FRAC_BITS-1:0]));
    assign ay = FW'($unsigned(y_coord[FRAC_BITS-1:0]));
    assign az = FW'($unsigned(z_coord[FRAC_BITS-1:0]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg[0] <= ax;
            fy_reg[0] <= ay;
            fz_reg[0] <= az;
            for (int i = 1; i < 3; i++)
            begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
        end
    end

    // Fade curves: results valid after three stages, then held along.
    logic signed [FW-1:0] su, sv, sw;
    pgn_fade u_fx (.clk(clk), .en(en), .t(x_coord[FRAC_BITS-1:0]), .fade(su));
    pgn_fade u_fy (.clk(clk), .en(en), .t(y_coord[FRAC_BITS-1:0]), .fade(sv));
    pgn_fade u_fz (.clk(clk), .en(en), .t(z_coord[FRAC_BITS-1:0]), .fade(sw));

    // Stage 1: first-level hashes.
    idx_t cz1_reg, ha_reg, hb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cz1_reg <= z_coord[FRAC_BITS +: 8];
            ha_reg  <= perm(x_coord[FRAC_BITS +: 8]) + y_coord[FRAC_BITS +: 8];
            hb_reg  <= perm(x_coord[FRAC_BITS +: 8] + 8'd1) + y_coord[FRAC_BITS +: 8];
        end
    end

    // Stage 2: second-level hashes.
    idx_t haa_reg, hab_reg, hba_reg, hbb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            haa_reg <= perm(ha_reg) + cz1_reg;
            hab_reg <= perm(ha_reg + 8'd1) + cz1_reg;
            hba_reg <= perm(hb_reg) + cz1_reg;
            hbb_reg <= perm(hb_reg + 8'd1) + cz1_reg;
        end
    end

    // Stage 3: corner gradient codes.
    logic [3:0] k_reg [8];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg[0] <= 4'(perm(haa_reg));
            k_reg[1] <= 4'(perm(hba_reg));
            k_reg[2] <= 4'(perm(hab_reg));
            k_reg[3] <= 4'(perm(hbb_reg));
            k_reg[4] <= 4'(perm(haa_reg + 8'd1));
            k_reg[5] <= 4'(perm(hba_reg + 8'd1));
            k_reg[6] <= 4'(perm(hab_reg + 8'd1));
            k_reg[7] <= 4'(perm(hbb_reg + 8'd1));
        end
    end

    // Stage 4: dot products; hold fades for later stages.
    logic signed [FW-1:0] n_reg [8];
    logic signed [FW-1:0] sv4_reg, sw4_reg, sw5_reg, sw6_reg;
    logic signed [FW-1:0] one;
    assign one = FW'(1 << FRAC_BITS);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 8; c++)
                n_reg[c] <= edge_dot(k_reg[c],
                    c[0] ? fx_reg[2] - one : fx_reg[2],
                    c[1] ? fy_reg[2] - one : fy_reg[2],
                    c[2] ? fz_reg[2] - one : fz_reg[2]);
            sv4_reg <= sv;
            sw4_reg <= sw;
        end
    end

    // Stage 4 side copies: su beside the dot products, sw carried into stage 5.
    logic signed [FW-1:0] su4_reg;
    logic signed [FW-1:0] lx_reg [4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su4_reg <= su;
            sw5_reg <= sw4_reg;
        end
    end
    // Stage 5: lerp along x; carry sv and sw alongside.
    logic signed [FW-1:0] sv5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
                lx_reg[j] <= n_reg[2*j] + fx_mul(su4_reg, n_reg[2*j+1] - n_reg[2*j]);
            sv5_reg <= sv4_reg;
            sw6_reg <= sw5_reg;
        end
    end

    // Stage 6: lerp along y.
    logic signed [FW-1:0] ly_reg [2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ly_reg[0] <= lx_reg[0] + fx_mul(sv5_reg, lx_reg[1] - lx_reg[0]);
            ly_reg[1] <= lx_reg[2] + fx_mul(sv5_reg, lx_reg[3] - lx_reg[2]);
        end
    end

    // Stage 7: lerp along z and saturate.
    logic signed [FW-1:0] r;
    logic signed [OUT_W-1:0] out_reg;
    assign r = ly_reg[0] + fx_mul(sw6_reg, ly_reg[1] - ly_reg[0]);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r > FW'(131071))
                out_reg <= OUT_W'(131071);
            else if (r < -FW'(131072))
                out_reg <= -OUT_W'(131072) ;
            else
                out_reg <= r[OUT_W-1:0];
        end
    end

    assign out_valid   = v_reg[NS-1];
    assign noise_value = out_reg;

    `PGN_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(noise_value), "result dropped under stall")
    `PGN_ASSERT_IMPL(a_stall, stall == (out_valid && out_stall), "stall not tied to output")
    `PGN_ASSERT_NEXT(a_flow, !stall && in_valid, v_reg[0], "accepted word not tracked")
endmodule
